@@ rtl/imu_complementary_filter_top_macros.svh @@
// Assertion macros shared by the checker.
`ifndef IMU_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_TOP_MACROS_SVH
// Clocked check, disabled while reset is low.
`define ICF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("icf check failed");
// Clocked check that also runs through reset.
`define ICF_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("icf reset check failed");
`endif

@@ rtl/icf_pkg.sv @@
// ----------------------------------------------------------------------------
// icf_pkg
// Types, codes and the arctangent table of the complementary filter.
// ----------------------------------------------------------------------------
`default_nettype none
package icf_pkg;

  localparam int CordicIters = 23;
  localparam int AngW        = 26;

  localparam logic [1:0] CFG_GYRO_LSB = 2'd0;
  localparam logic [1:0] CFG_PERIOD   = 2'd1;
  localparam logic [1:0] CFG_BLEND    = 2'd2;

  typedef enum logic [2:0] {
    T_IDLE, T_SQ1, T_SQ2, T_ROOT, T_VINIT, T_ROT, T_DONE
  } tilt_state_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TY, S_TYW, S_TX, S_TXW, S_GW, S_GHI, S_GLO, S_GSUM,
    S_GYRO, S_DIFF, S_BHI, S_BLO, S_BSUM, S_BOUT, S_PUSH
  } top_state_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD_HI, ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic              mul_en;
    acc_op_t           acc_op;
    logic signed [24:0] op_a;
    logic signed [24:0] op_b;
  } mac_ctl_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    unique case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/imu_complementary_filter_top.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_filter_top
// Complementary attitude filter: accel tilt blended with integrated gyro.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one IMU beat: three accel and
//   three gyro axes. Output channel (out_valid/out_ready) carries the three
//   blended Q16.16 angles. The config port writes gyro weight, sample period
//   and blend weight at the index given on cfg_addr; write only when idle.
//   From the accepting edge to out_valid, each of the
//   two tilt angles passes through the tilt engine (start, two square
//   steps, 30 square-root steps, init, 23 CORDIC rotations, done), each
//   axis then passes through the shared multiplier sequence (gyro
//   scale, integrate, blend), and then the output register is loaded.
//   A zero acceleration vector skips the rotations. in_ready is
//   high only in idle, so a new beat is taken only once the last one
//   is through the datapath.
//   Reset returns the headings to zero, loads the default registers and
//   drops any pending result. A result waits in the output register while
//   out_ready is low; the next beat is accepted meanwhile, and its result
//   is held internally until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
module imu_complementary_filter_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire signed [15:0]  in_accel_x,
  input  wire signed [15:0]  in_accel_y,
  input  wire signed [15:0]  in_accel_z,
  input  wire signed [15:0]  in_rate_x,
  input  wire signed [15:0]  in_rate_y,
  input  wire signed [15:0]  in_rate_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] out_angle_x,
  output logic signed [31:0] out_angle_y,
  output logic signed [31:0] out_angle_z,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_addr,
  input  wire [23:0]         cfg_wdata
);
  import icf_pkg::*;

  top_state_t state_r, state_nxt;

  // configuration
  logic [23:0] gyro_w_r, period_r;
  logic [16:0] blend_r;
  logic [16:0] blend_a;

  // latched sample
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [15:0] rate_r [3];

  logic signed [31:0] heading_r [3];
  logic [1:0]         axis_r;

  logic signed [25:0] tilt_y_r, tilt_x_r, tsel_r;
  logic signed [37:0] gyro_r;
  logic signed [38:0] diff_r;
  logic [19:0]        lo_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;

  // tilt engine
  logic               t_start, t_done;
  logic signed [15:0] t_num, t_o1;
  logic signed [25:0] t_angle;

  // shared multiplier
  mac_ctl_t           mac;
  logic signed [49:0] prod;
  logic signed [63:0] acc;

  logic signed [64:0] rnd;
  logic signed [36:0] delta;
  logic signed [63:0] bias, vsum;
  logic signed [47:0] vsh;
  logic signed [31:0] vsat;
  logic signed [25:0] tsel;

  assign blend_a = (blend_r > 17'd65536) ? 17'd65536 : blend_r;

  icf_tilt u_tilt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (t_start),
    .num   (t_num),
    .o1    (t_o1),
    .o2    (az_r),
    .done  (t_done),
    .angle (t_angle)
  );

  icf_mac u_mac (
    .clk  (clk),
    .ctl  (mac),
    .prod (prod),
    .acc  (acc)
  );

  // gyro round and shift, blend bias and saturation
  assign rnd   = {acc[63], acc} + 65'sd134217728;
  assign delta = rnd[64:28];
  assign tsel  = (axis_r == 2'd0) ? tilt_y_r : -tilt_x_r;
  assign bias  = {{22{tsel_r[25]}}, tsel_r, 16'h8000};
  assign vsum  = acc + bias;
  assign vsh   = vsum[63:16];

  always_comb begin
    if (vsh[47:31] == 17'd0 || vsh[47:31] == 17'h1FFFF) begin
      vsat = vsh[31:0];
    end else if (vsh[47]) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = 32'sh7FFFFFFF;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_TY;
      S_TY:   state_nxt = S_TYW;
      S_TYW:  if (t_done) state_nxt = S_TX;
      S_TX:   state_nxt = S_TXW;
      S_TXW:  if (t_done) state_nxt = S_GW;
      S_GW:   state_nxt = S_GHI;
      S_GHI:  state_nxt = S_GLO;
      S_GLO:  state_nxt = S_GSUM;
      S_GSUM: state_nxt = S_GYRO;
      S_GYRO: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_BHI;
      S_BHI:  state_nxt = S_BLO;
      S_BLO:  state_nxt = S_BSUM;
      S_BSUM: state_nxt = S_BOUT;
      S_BOUT: state_nxt = (axis_r == 2'd2) ? S_PUSH : S_GW;
      S_PUSH: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    t_start     = (state_r == S_TY) || (state_r == S_TX);
    t_num       = (state_r == S_TY) ? ay_r : ax_r;
    t_o1        = (state_r == S_TY) ? ax_r : ay_r;
    mac.mul_en  = 1'b0;
    mac.acc_op  = ACC_HOLD;
    mac.op_a    = '0;
    mac.op_b    = '0;
    unique case (state_r)
      S_GW: begin
        mac.mul_en = 1'b1;
        mac.op_a   = 25'(rate_r[axis_r]);
        mac.op_b   = {1'b0, gyro_w_r};
      end
      S_GHI: begin
        mac.mul_en = 1'b1;
        mac.op_a   = 25'(signed'(prod[39:20]));
        mac.op_b   = {1'b0, period_r};
      end
      S_GLO: begin
        mac.mul_en = 1'b1;
        mac.acc_op = ACC_LOAD_HI;
        mac.op_a   = {5'd0, lo_r};
        mac.op_b   = {1'b0, period_r};
      end
      S_BHI: begin
        mac.mul_en = 1'b1;
        mac.op_a   = 25'(signed'(diff_r[38:20]));
        mac.op_b   = {8'd0, blend_a};
      end
      S_BLO: begin
        mac.mul_en = 1'b1;
        mac.acc_op = ACC_LOAD_HI;
        mac.op_a   = {5'd0, lo_r};
        mac.op_b   = {8'd0, blend_a};
      end
      S_GSUM, S_BSUM: mac.acc_op = ACC_ADD;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gyro_w_r     <= 24'd64000;
      period_r     <= 24'd167772;
      blend_r      <= 17'd64225;
      heading_r[0] <= '0;
      heading_r[1] <= '0;
      heading_r[2] <= '0;
      out_valid_r  <= 1'b0;
      axis_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_GYRO_LSB: gyro_w_r <= cfg_wdata;
          CFG_PERIOD:   period_r <= cfg_wdata;
          CFG_BLEND:    blend_r  <= cfg_wdata[16:0];
          default: ;
        endcase
      end
      if (state_r == S_TY) begin
        axis_r <= '0;
      end
      if (state_r == S_BOUT) begin
        heading_r[axis_r] <= vsat;
        axis_r            <= axis_r + 2'd1;
      end
      // load a new result, or drop the one just taken
      if (state_r == S_PUSH && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r      <= in_accel_x;
      ay_r      <= in_accel_y;
      az_r      <= in_accel_z;
      rate_r[0] <= in_rate_x;
      rate_r[1] <= in_rate_y;
      rate_r[2] <= in_rate_z;
    end
    if (state_r == S_TYW && t_done) tilt_y_r <= t_angle;
    if (state_r == S_TXW && t_done) tilt_x_r <= t_angle;
    if (state_r == S_GHI) lo_r <= prod[19:0];
    if (state_r == S_BHI) lo_r <= diff_r[19:0];
    if (state_r == S_GYRO) begin
      gyro_r <= 38'(heading_r[axis_r]) + 38'(delta);
    end
    if (state_r == S_DIFF) begin
      diff_r <= 39'(gyro_r) - 39'(tsel);
      tsel_r <= tsel;
    end
    if (state_r == S_PUSH && (!out_valid_r || out_ready)) begin
      out_x_r <= heading_r[0];
      out_y_r <= heading_r[1];
      out_z_r <= heading_r[2];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_angle_x = out_x_r;
  assign out_angle_y = out_y_r;
  assign out_angle_z = out_z_r;
endmodule
`default_nettype wire

@@ rtl/icf_mac.sv @@
// ----------------------------------------------------------------------------
// icf_mac
// Shared 25x25 signed multiplier with registered product and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module icf_mac (
  input  wire                 clk,
  input  icf_pkg::mac_ctl_t   ctl,
  output logic signed [49:0]  prod,
  output logic signed [63:0]  acc
);
  import icf_pkg::*;

  logic signed [49:0] prod_r;
  logic signed [63:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= ctl.op_a * ctl.op_b;
    end
    unique case (ctl.acc_op)
      ACC_LOAD_HI: acc_r <= {prod_r[43:0], 20'd0};
      ACC_ADD:     acc_r <= acc_r + {{14{prod_r[49]}}, prod_r};
      default:     acc_r <= acc_r;
    endcase
  end

  assign prod = prod_r;
  assign acc  = acc_r;
endmodule
`default_nettype wire

@@ rtl/icf_tilt.sv @@
// ----------------------------------------------------------------------------
// icf_tilt
// Tilt angle asin(num/|v|): square sum, bit-serial root, vectoring CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none
module icf_tilt (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire signed [15:0]  num,
  input  wire signed [15:0]  o1,
  input  wire signed [15:0]  o2,
  output logic               done,
  output logic signed [25:0] angle
);
  import icf_pkg::*;

  tilt_state_t state_r, state_nxt;

  logic signed [15:0] num_r, o1_r, o2_r;
  logic [31:0]        sq_r;
  logic [59:0]        n_r;
  logic [60:0]        res_r;
  logic [59:0]        bit_r;
  logic signed [33:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic [4:0]         i_r;

  logic signed [31:0] sqr_a;
  logic [60:0]        trial;
  logic signed [33:0] dx, dy;

  assign sqr_a = (state_r == T_SQ1) ? o1_r * o1_r : o2_r * o2_r;
  assign trial = res_r + {1'b0, bit_r};
  assign dx    = y_r >>> i_r;
  assign dy    = x_r >>> i_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (start) state_nxt = T_SQ1;
      T_SQ1:   state_nxt = T_SQ2;
      T_SQ2:   state_nxt = T_ROOT;
      T_ROOT:  if (bit_r[0]) state_nxt = T_VINIT;
      T_VINIT: state_nxt = (res_r == 61'd0 && num_r == 16'sd0) ? T_DONE : T_ROT;
      T_ROT:   if (i_r == 5'(CordicIters - 1)) state_nxt = T_DONE;
      T_DONE:  state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == T_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      T_IDLE: begin
        num_r <= num;
        o1_r  <= o1;
        o2_r  <= o2;
      end
      T_SQ1: sq_r <= 32'(sqr_a);
      T_SQ2: begin
        n_r   <= {sq_r + 32'(sqr_a), 28'd0};
        res_r <= '0;
        bit_r <= 60'd1 << 58;
      end
      T_ROOT: begin
        if ({1'b0, n_r} >= trial) begin
          n_r   <= 60'({1'b0, n_r} - trial);
          res_r <= (res_r >> 1) + {1'b0, bit_r};
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      T_VINIT: begin
        x_r <= {3'd0, res_r[30:0]};
        y_r <= {{4{num_r[15]}}, num_r, 14'd0};
        z_r <= '0;
        i_r <= '0;
      end
      T_ROT: begin
        if (y_r > 34'sd0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_deg(i_r);
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_deg(i_r);
        end
        i_r <= i_r + 5'd1;
      end
      default: ;
    endcase
  end

  assign angle = z_r;
endmodule
`default_nettype wire

@@ rtl/icf_checker.sv @@
// ----------------------------------------------------------------------------
// icf_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "imu_complementary_filter_top_macros.svh"
module icf_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [31:0] out_angle_x
);
  // stalled result stays valid and angle_x holds
  `ICF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_angle_x))
  // busy right after taking a beat
  `ICF_ASSERT(a_busy, in_valid && in_ready |=> !in_ready)
  // no result appears right after a beat is taken
  `ICF_ASSERT(a_no_early, in_valid && in_ready |=> !$rose(out_valid))
  // reset drops any pending result
  `ICF_ASSERT_RST(a_rst, !rst_n |=> !out_valid)
endmodule

bind imu_complementary_filter_top icf_checker u_icf_checker (.*);
`default_nettype wire

@@ dv/imu_complementary_filter_top_test.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_filter_top_test
// Self-checking bench: directed and random IMU beats checked against a
// bit-exact filter model kept in the bench, across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none
module imu_complementary_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import icf_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } imu_beat_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } attitude_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic signed [15:0] in_rate_x = '0, in_rate_y = '0, in_rate_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_angle_x, out_angle_y, out_angle_z;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  imu_complementary_filter_top DUT (.*);

  // Model state: registers and stored headings.
  logic [23:0] lsb_weight, period;
  logic [16:0] blend_w;
  logic signed [31:0] head_x, head_y, head_z;

  imu_beat_t pending_beats[$];
  attitude_t expected_attitudes[$];
  int errors = 0;
  int idle_cycles = 0;
  int in_gap = 0, out_gap = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Append one beat to the tail of the pending queue.
  task automatic add_beat(imu_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan_tab(int i);
    longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                      29, 14, 7, 4, 2, 1};
    return t[i];
  endfunction

  // asin(num/|a|) via vectoring CORDIC; shifts on longint are arithmetic.
  function automatic longint tilt_angle(longint num, longint o1, longint o2);
    longint cx, cy, cz, dx, dy;
    longint unsigned sq;
    sq = o1 * o1 + o2 * o2;
    cx = int_sqrt(sq << 28);
    cy = num * 16384;
    cz = 0;
    if (cx == 0 && cy == 0) return 0;
    for (int i = 0; i < CordicIters; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx += dx; cy -= dy; cz += atan_tab(i);
      end else begin
        cx -= dx; cy += dy; cz -= atan_tab(i);
      end
    end
    return cz;
  endfunction

  function automatic longint rate_step(longint rate);
    longint p;
    p = rate * longint'(lsb_weight) * longint'(period);
    return (p + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic logic signed [31:0] mix(longint g, longint acc, longint a);
    longint v;
    v = ((a * g + (65536 - a) * acc) + 32768) >>> 16;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_attitude(imu_beat_t b);
    longint a, ty, tx;
    attitude_t r;
    a = (blend_w > 17'd65536) ? 65536 : longint'(blend_w);
    ty = tilt_angle(b.ay, b.ax, b.az);
    tx = tilt_angle(b.ax, b.ay, b.az);
    head_x = mix(longint'(head_x) + rate_step(b.gx), ty, a);
    head_y = mix(longint'(head_y) + rate_step(b.gy), -tx, a);
    head_z = mix(longint'(head_z) + rate_step(b.gz), -tx, a);
    r.x = head_x; r.y = head_y; r.z = head_z;
    expected_attitudes.insert(expected_attitudes.size(), r);
  endtask

  // Driver: present beats from the queue, honoring a random gap per beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_attitude('{in_accel_x, in_accel_y, in_accel_z,
                           in_rate_x, in_rate_y, in_rate_z});
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0 || pending_beats.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          imu_beat_t b;
          b = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_accel_x <= b.ax; in_accel_y <= b.ay; in_accel_z <= b.az;
          in_rate_x <= b.gx; in_rate_y <= b.gy; in_rate_z <= b.gz;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_attitudes.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          attitude_t e;
          e = expected_attitudes.pop_front();
          if (out_angle_x !== e.x) begin
            $error("angle_x exp %0d got %0d", e.x, out_angle_x); errors++;
          end
          if (out_angle_y !== e.y) begin
            $error("angle_y exp %0d got %0d", e.y, out_angle_y); errors++;
          end
          if (out_angle_z !== e.z) begin
            $error("angle_z exp %0d got %0d", e.z, out_angle_z); errors++;
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Wait for an edge first so back-to-back writes never collide on cfg_we.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GYRO_LSB: lsb_weight = val;
      CFG_PERIOD:   period = val;
      CFG_BLEND:    blend_w = val[16:0];
      default: ;
    endcase
  endtask

  // Wait until every beat is through, then let the pipeline drain.
  task automatic drain;
    while (pending_beats.size() != 0 || in_valid || expected_attitudes.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_beats(int n);
    imu_beat_t b;
    for (int i = 0; i < n; i++) begin
      b = '{rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
      if ($urandom_range(0, 15) == 0) begin
        b.ax = 0; b.ay = 0; b.az = 0;          // zero vector
      end else if ($urandom_range(0, 15) == 0) begin
        b.ax = 0; b.az = 0;                    // pure Y tilt
      end
      add_beat(b);
    end
  endtask

  initial begin
    logic [23:0] gw[5] = '{24'd64000, 24'd0, 24'hffffff, 24'd1048576, 24'd64000};
    logic [23:0] sp[5] = '{24'd167772, 24'hffffff, 24'd0, 24'hffffff, 24'd1};
    logic [23:0] bw[5] = '{24'd64225, 24'd65536, 24'd0, 24'h1ffff, 24'd32768};
    lsb_weight = 24'd64000; period = 24'd167772; blend_w = 17'd64225;
    head_x = 0; head_y = 0; head_z = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, zero vector, zero horizontal parts.
    add_beat('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    add_beat('{16'sd0, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sh8000, 16'sd1});
    add_beat('{16'sd0, 16'sh8000, 16'sd0, -16'sd1, 16'sd0, 16'sh7fff});
    add_beat('{16'sh7fff, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff, 16'sh8000});
    add_beat('{16'sh8000, 16'sd0, 16'sd0, 16'sd100, 16'sd0, -16'sd100});
    add_beat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    add_beat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    add_beat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    add_beat('{16'sh5555, -16'sd21846, 16'sd1, 16'sh5555, -16'sd21846, 16'sd1});
    drain();
    // Register settings, including saturating gyro steps and blend above one.
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_GYRO_LSB, gw[p]);
      write_reg(CFG_PERIOD, sp[p]);
      write_reg(CFG_BLEND, bw[p]);
      queue_beats(p == 0 ? 250 : 100);
      drain();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
